>>> hw/rtl/b2s_pkg.sv
// ----------------------------------------------------------------------------
// b2s_pkg
// Shared types, constants and helper functions of the BLAKE2s hash engine.
// ----------------------------------------------------------------------------
package b2s_pkg;

    typedef logic [31:0]         word_t;
    typedef logic [7:0][31:0]    chain_t;
    typedef logic [15:0][31:0]   vec_t;

    // Command from the block controller to the compression core
    typedef struct packed {
        logic start;
        logic last_blk;
    } b2s_cmd_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ALL_ONES      = 32'hFFFFFFFF;
    localparam word_t PARAM_BASE    = 32'h01010000;
    localparam logic [5:0] MAX_LEN  = 6'd32;
    localparam int unsigned ROUNDS  = 10;

    // Message schedule row of a round, position 0 in the low nibble
    function automatic logic [63:0] sigma_row(input logic [3:0] rnd);
        logic [63:0] row;
        begin
            case (rnd)
                4'd0:    row = 64'hfedcba9876543210;
                4'd1:    row = 64'h357b20c16df984ae;
                4'd2:    row = 64'h491763eadf250c8b;
                4'd3:    row = 64'h8f04a562ebcd1397;
                4'd4:    row = 64'hd386cb1efa427509;
                4'd5:    row = 64'h91ef57d438b0a6c2;
                4'd6:    row = 64'hb8293670a4def15c;
                4'd7:    row = 64'ha2684f05931ce7bd;
                4'd8:    row = 64'h5a417d2c803b9ef6;
                4'd9:    row = 64'h0dc3e9bf5167482a;
                default: row = 64'hfedcba9876543210;
            endcase
            return row;
        end
    endfunction

    function automatic logic [3:0] sigma_pick(input logic [3:0] rnd, input logic [3:0] pos);
        logic [63:0] row;
        begin
            row = sigma_row(rnd);
            return row[{pos, 2'b00} +: 4];
        end
    endfunction

    function automatic logic [5:0] eff_out_len(input logic [5:0] len);
        begin
            if (len == 6'd0)
                return 6'd1;
            else if (len > MAX_LEN)
                return MAX_LEN;
            else
                return len;
        end
    endfunction

    function automatic logic [5:0] eff_key_len(input logic [5:0] len);
        begin
            return (len > MAX_LEN) ? MAX_LEN : len;
        end
    endfunction

    // Initial chaining value with the parameter block folded into word 0
    function automatic chain_t init_chain(input logic [5:0] out_len, input logic [5:0] key_len);
        chain_t ch;
        begin
            for (int i = 0; i < 8; i++)
                ch[i] = IV[i];
            ch[0] = ch[0] ^ PARAM_BASE ^ {18'd0, eff_key_len(key_len), 8'd0}
                    ^ {26'd0, eff_out_len(out_len)};
            return ch;
        end
    endfunction

endpackage

>>> hw/rtl/b2s_mix_unit.sv
// ----------------------------------------------------------------------------
// b2s_mix_unit
// One quarter of the G function: an add and a rotate per cycle.
// ----------------------------------------------------------------------------
module b2s_mix_unit
    import b2s_pkg::*;
(
    input  word_t       a,
    input  word_t       b,
    input  word_t       c,
    input  word_t       d,
    input  word_t       x,
    input  logic [1:0]  step,
    output word_t       a_out,
    output word_t       b_out,
    output word_t       c_out,
    output word_t       d_out
);

    word_t sum_a;
    word_t sum_c;
    word_t xor_d;
    word_t xor_b;

    always_comb
    begin
        sum_a = a + b + x;
        sum_c = c + d;
        xor_d = d ^ sum_a;
        xor_b = b ^ sum_c;
        a_out = a;
        b_out = b;
        c_out = c;
        d_out = d;
        case (step)
            2'd0:
            begin
                a_out = sum_a;
                d_out = {xor_d[15:0], xor_d[31:16]};
            end
            2'd1:
            begin
                c_out = sum_c;
                b_out = {xor_b[11:0], xor_b[31:12]};
            end
            2'd2:
            begin
                a_out = sum_a;
                d_out = {xor_d[7:0], xor_d[31:8]};
            end
            2'd3:
            begin
                c_out = sum_c;
                b_out = {xor_b[6:0], xor_b[31:7]};
            end
            default:
            begin
                a_out = a;
            end
        endcase
    end

endmodule

>>> hw/rtl/b2s_compress_core.sv
// ----------------------------------------------------------------------------
// b2s_compress_core
// Compression function: holds the work vector and steps the shared mix unit
// through 10 rounds of 8 G calls, 4 quarter steps each.
// ----------------------------------------------------------------------------
module b2s_compress_core
    import b2s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  b2s_cmd_t    cmd,
    input  chain_t      chain_in,
    input  logic [63:0] counter,
    output logic [3:0]  msg_idx,
    input  word_t       msg_word,
    output logic        done,
    output chain_t      chain_out
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_DONE = 2'd2;
    localparam logic [3:0] LAST_ROUND = 4'(ROUNDS - 1);

    logic [1:0] state_reg, state_next;
    logic [3:0] round_reg, round_next;
    logic [2:0] g_reg, g_next;
    logic [1:0] step_reg, step_next;
    vec_t       v_reg, v_next;

    word_t a_o, b_o, c_o, d_o;
    vec_t  v_mix;
    vec_t  v_rot;
    logic [1:0] k;
    logic [1:0] src;

    b2s_mix_unit u_mix (
        .a     (v_reg[0]),
        .b     (v_reg[4]),
        .c     (v_reg[8]),
        .d     (v_reg[12]),
        .x     (msg_word),
        .step  (step_reg),
        .a_out (a_o),
        .b_out (b_o),
        .c_out (c_o),
        .d_out (d_o)
    );

    assign msg_idx = sigma_pick(round_reg, {g_reg, step_reg[1]});
    assign done    = (state_reg == C_DONE);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            chain_out[i] = chain_in[i] ^ v_reg[i] ^ v_reg[i + 8];
    end

    // The active G always works on column 0; rotate rows after each G so
    // the next column, or the next diagonal, lands there.
    always_comb
    begin
        k   = 2'd1;
        src = 2'd0;
        v_mix     = v_reg;
        v_mix[0]  = a_o;
        v_mix[4]  = b_o;
        v_mix[8]  = c_o;
        v_mix[12] = d_o;
        v_rot = v_mix;
        for (int r = 0; r < 4; r++)
        begin
            case (g_reg)
                3'd3:    k = 2'(1 + r);
                3'd7:    k = 2'(1 - r);
                default: k = 2'd1;
            endcase
            for (int p = 0; p < 4; p++)
            begin
                src = 2'(p) + k;
                v_rot[4 * r + p] = v_mix[4 * r + int'(src)];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        g_next     = g_reg;
        step_next  = step_reg;
        v_next     = v_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.start)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v_next[i]     = chain_in[i];
                        v_next[i + 8] = IV[i];
                    end
                    v_next[12] = IV[4] ^ counter[31:0];
                    v_next[13] = IV[5] ^ counter[63:32];
                    v_next[14] = cmd.last_blk ? (IV[6] ^ ALL_ONES) : IV[6];
                    round_next = 4'd0;
                    g_next     = 3'd0;
                    step_next  = 2'd0;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                v_next    = (step_reg == 2'd3) ? v_rot : v_mix;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    g_next = g_reg + 3'd1;
                    if (g_reg == 3'd7)
                    begin
                        round_next = round_reg + 4'd1;
                        if (round_reg == LAST_ROUND)
                            state_next = C_DONE;
                    end
                end
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= 4'd0;
            g_reg     <= 3'd0;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            g_reg     <= g_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

endmodule

>>> hw/rtl/blake2s_hash_engine_top.sv
// ----------------------------------------------------------------------------
// blake2s_hash_engine_top
// BLAKE2s hash engine: byte-packing block buffer, APB registers, and the
// iterative compression core; emits the digest on the last input word.
// ----------------------------------------------------------------------------
// Input: s_tready is low while a word's bytes are appended, so a new word is
//   taken only once the last one is through; a byte landing on a full block
//   first waits for a compression (1 load, 320 quarter-G steps on the shared
//   mix unit, 1 fold). Last word: its bytes, the final compression, then the
//   digest words, one per cycle while m_tready is high.
// Reset clears control state; a message's first word reloads the chain value.
module blake2s_hash_engine_top
    import b2s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  logic        s_tlast,   // end_of_message
    // Digest stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast,   // digest_last
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BYTES = 2'd1;
    localparam logic [1:0] S_COMP  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    localparam logic REG_OUT_LEN = 1'b0;
    localparam logic REG_KEY_LEN = 1'b1;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  out_len_reg, key_len_reg;
    chain_t      chain_reg, chain_next;
    logic [63:0] counter_reg, counter_next;
    vec_t        buf_reg, buf_next;
    logic [6:0]  fill_reg, fill_next;
    word_t       data_reg, data_next;
    logic [2:0]  left_reg, left_next;     // bytes of the held word still to append
    logic        eom_reg, eom_next;
    logic        last_blk_reg, last_blk_next;
    b2s_cmd_t    cmd_reg, cmd_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_valid_reg, out_valid_next;
    word_t       out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic        in_fire;
    logic        cfg_wr;
    logic [2:0]  cnt_in;
    logic [3:0]  msg_idx;
    logic        core_done;
    chain_t      core_chain;
    logic [5:0]  len_eff;
    logic [4:0]  len_m1;

    assign in_fire  = s_tvalid & s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // The user must write the registers only while the engine is idle; the block itself does not enforce it.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_KEY_LEN) ? {26'd0, key_len_reg} : {26'd0, out_len_reg};

    // Clamp byte counts above four
    assign cnt_in = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

    assign len_eff = eff_out_len(out_len_reg);
    assign len_m1  = 5'(len_eff - 6'd1);

    b2s_compress_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_reg),
        .chain_in  (chain_reg),
        .counter   (counter_reg),
        .msg_idx   (msg_idx),
        .msg_word  (buf_reg[msg_idx]),
        .done      (core_done),
        .chain_out (core_chain)
    );

    // Digest word i, bytes at or beyond the digest length zeroed
    function automatic word_t digest_at(input chain_t ch, input logic [2:0] i,
                                        input logic [5:0] len);
        word_t w;
        logic [5:0] pos;
        begin
            w = ch[i];
            for (int k = 0; k < 4; k++)
            begin
                pos = {1'b0, i, 2'(k)};
                if (pos >= len)
                    w[8 * k +: 8] = 8'd0;
            end
            return w;
        end
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        counter_next   = counter_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        data_next      = data_reg;
        left_next      = left_reg;
        eom_next       = eom_reg;
        last_blk_next  = last_blk_reg;
        cmd_next       = '0;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // Fresh message: reload chaining value from current registers
                    if ((counter_reg == 64'd0) && (fill_reg == 7'd0))
                        chain_next = init_chain(out_len_reg, key_len_reg);
                    data_next  = s_tdata[31:0];
                    left_next  = cnt_in;
                    eom_next   = s_tlast;
                    state_next = S_BYTES;
                end
            end
            S_BYTES:
            begin
                if (left_reg == 3'd0)
                begin
                    if (eom_reg)
                    begin
                        // Close the message with the final block
                        counter_next  = counter_reg + {57'd0, fill_reg};
                        last_blk_next = 1'b1;
                        cmd_next      = '{start: 1'b1, last_blk: 1'b1};
                        state_next    = S_COMP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (fill_reg[6])
                begin
                    // Buffer full and more data follows: compress it first
                    counter_next  = counter_reg + 64'd64;
                    last_blk_next = 1'b0;
                    cmd_next      = '{start: 1'b1, last_blk: 1'b0};
                    state_next    = S_COMP;
                end
                else
                begin
                    buf_next[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] = data_reg[7:0];
                    fill_next = fill_reg + 7'd1;
                    data_next = {8'd0, data_reg[31:8]};
                    left_next = left_reg - 3'd1;
                end
            end
            S_COMP:
            begin
                if (core_done)
                begin
                    chain_next = core_chain;
                    buf_next   = '0;
                    fill_next  = 7'd0;
                    if (last_blk_reg)
                    begin
                        // Start of the next message
                        counter_next   = 64'd0;
                        out_idx_next   = 3'd0;
                        out_valid_next = 1'b0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_BYTES;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_data_next  = digest_at(chain_reg, out_idx_reg, len_eff);
                    out_last_next  = (out_idx_reg == len_m1[4:2]);
                    out_valid_next = 1'b1;
                end
                else if (m_tready)
                begin
                    if (out_last_reg)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        // Advance to the next digest word without a bubble
                        out_idx_next  = out_idx_reg + 3'd1;
                        out_data_next = digest_at(chain_reg, out_idx_reg + 3'd1, len_eff);
                        out_last_next = ((out_idx_reg + 3'd1) == len_m1[4:2]);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_len_reg   <= MAX_LEN;
            key_len_reg   <= 6'd0;
            chain_reg     <= init_chain(MAX_LEN, 6'd0);
            counter_reg   <= 64'd0;
            buf_reg       <= '0;
            fill_reg      <= 7'd0;
            left_reg      <= 3'd0;
            eom_reg       <= 1'b0;
            last_blk_reg  <= 1'b0;
            cmd_reg       <= '0;
            out_idx_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            counter_reg   <= counter_next;
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            eom_reg       <= eom_next;
            last_blk_reg  <= last_blk_next;
            cmd_reg       <= cmd_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_OUT_LEN: out_len_reg <= pwdata[5:0];
                    REG_KEY_LEN: key_len_reg <= pwdata[5:0];
                    default:     out_len_reg <= out_len_reg;
                endcase
            end
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> tb/tb_blake2s_hash_engine_top.sv
// ----------------------------------------------------------------------------
// tb_blake2s_hash_engine_top
// Self-checking bench for the BLAKE2s hash engine. A directed table covers
// the published digests, field extremes, short and oversized byte counts, a
// two-block message and register edge values, including a register change in
// the middle of a message. Random phases follow with plain and keyed
// messages under changing registers. Each digest word is compared with the
// bench's bit-accurate hash model, or a published digest on known-answer rows.
// ----------------------------------------------------------------------------
module tb_blake2s_hash_engine_top
    import b2s_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_OUT_LEN  = 3'd0;
    localparam logic [2:0] ADDR_KEY_LEN  = 3'd4;
    localparam int         SETTLE_CYCLES = 400;   // > one block compression
    localparam int         HOLD_CYCLES   = 1500;  // long receiver hold-off
    localparam int         PHASES        = 10;
    localparam int         PHASE_WORDS   = 20;

    localparam word_t IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int SIGMA [10][16] = '{
        '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
        '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
        '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
        '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
        '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
        '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
        '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
        '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
        '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
        '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
    };

    // Published BLAKE2s-256 digests, packed little-endian per word
    localparam word_t EMPTY_DIGEST [8] = '{
        32'h307a2169, 32'h94809079, 32'hd02111e1, 32'h7c4a3542,
        32'h48b6551f, 32'h1ea5a12c, 32'hfd0d251b, 32'hf9eed01e
    };
    localparam word_t ABC_DIGEST [8] = '{
        32'h8c5e8c50, 32'he2147c32, 32'ha32ba7e1, 32'h2f45eb4e,
        32'h208b4537, 32'h293ad69e, 32'h4c9b994d, 32'h82596786
    };

    typedef enum logic [1:0] {ROW_WORD, ROW_OUT_LEN, ROW_KEY_LEN} row_kind_t;
    typedef enum logic [1:0] {KAT_NONE, KAT_EMPTY_MSG, KAT_ABC_MSG} kat_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] data;   // message word, or register value
        logic [2:0]  cnt;
        logic        eom;    // applies to the last repetition only
        logic [4:0]  reps;
        kat_t        kat;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_t;

    localparam int DIR_ROWS = 17;

    stim_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_WORD,    32'h00000000, 3'd0, 1'b1, 5'd1,  KAT_EMPTY_MSG}, // empty message
        '{ROW_WORD,    32'hff636261, 3'd3, 1'b1, 5'd1,  KAT_ABC_MSG},   // "abc", junk top byte
        '{ROW_WORD,    32'hffffffff, 3'd7, 1'b0, 5'd1,  KAT_NONE},      // count above 4
        '{ROW_WORD,    32'h12345678, 3'd2, 1'b0, 5'd1,  KAT_NONE},      // short, not last
        '{ROW_WORD,    32'h00000000, 3'd4, 1'b0, 5'd1,  KAT_NONE},
        '{ROW_WORD,    32'ha5a5a5a5, 3'd4, 1'b1, 5'd1,  KAT_NONE},
        '{ROW_WORD,    32'h89abcdef, 3'd4, 1'b0, 5'd16, KAT_NONE},      // fill one block
        '{ROW_WORD,    32'h00000080, 3'd1, 1'b1, 5'd1,  KAT_NONE},      // spill into second
        '{ROW_OUT_LEN, 32'd0,        3'd0, 1'b0, 5'd0,  KAT_NONE},      // zero -> 1 byte
        '{ROW_KEY_LEN, 32'd63,       3'd0, 1'b0, 5'd0,  KAT_NONE},      // clamps to 32
        '{ROW_WORD,    32'hffffffff, 3'd4, 1'b1, 5'd1,  KAT_NONE},
        '{ROW_OUT_LEN, 32'd63,       3'd0, 1'b0, 5'd0,  KAT_NONE},      // clamps to 32
        '{ROW_WORD,    32'h01020304, 3'd4, 1'b0, 5'd1,  KAT_NONE},
        '{ROW_OUT_LEN, 32'd5,        3'd0, 1'b0, 5'd0,  KAT_NONE},      // mid-message change
        '{ROW_WORD,    32'h00000000, 3'd0, 1'b1, 5'd1,  KAT_NONE},
        '{ROW_OUT_LEN, 32'd32,       3'd0, 1'b0, 5'd0,  KAT_NONE},
        '{ROW_KEY_LEN, 32'd0,        3'd0, 1'b0, 5'd0,  KAT_NONE}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    logic        s_tlast;   // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic        m_tlast;   // digest_last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blake2s_hash_engine_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Hash model state: registers, chaining value, byte count, block
    // ------------------------------------------------------------------
    logic [5:0]  cfg_out_len;
    logic [5:0]  cfg_key_len;
    word_t       chain_h [8];
    logic [63:0] msg_bytes;
    word_t       blk_words [16];
    int          blk_fill;
    word_t       wv [16];

    digest_t     digest_q [$];   // digest words still owed by the engine

    int err_cnt;
    int n_words;
    int n_msgs;
    int n_keyed;
    int n_digest;
    int n_reg_writes;
    int sink_hold;
    bit src_burst;
    bit sink_burst;

    function automatic int digest_bytes();
        if (cfg_out_len == 6'd0)
            return 1;
        if (cfg_out_len > 6'd32)
            return 32;
        return int'(cfg_out_len);
    endfunction

    function automatic int key_bytes();
        return (cfg_key_len > 6'd32) ? 32 : int'(cfg_key_len);
    endfunction

    function automatic void load_chain();
        for (int i = 0; i < 8; i++)
            chain_h[i] = IV_WORDS[i];
        chain_h[0] = chain_h[0] ^ 32'h01010000 ^ (word_t'(key_bytes()) << 8)
                     ^ word_t'(digest_bytes());
    endfunction

    function automatic void fresh_message();
        load_chain();
        msg_bytes = '0;
        blk_fill  = 0;
        for (int i = 0; i < 16; i++)
            blk_words[i] = '0;
    endfunction

    function automatic word_t ror32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void g_mix(input int a, input int b, input int c, input int d,
                                  input word_t x, input word_t y);
        wv[a] = wv[a] + wv[b] + x;
        wv[d] = ror32(wv[d] ^ wv[a], 16);
        wv[c] = wv[c] + wv[d];
        wv[b] = ror32(wv[b] ^ wv[c], 12);
        wv[a] = wv[a] + wv[b] + y;
        wv[d] = ror32(wv[d] ^ wv[a], 8);
        wv[c] = wv[c] + wv[d];
        wv[b] = ror32(wv[b] ^ wv[c], 7);
    endfunction

    function automatic void hash_compress(input bit final_blk);
        for (int i = 0; i < 8; i++)
        begin
            wv[i]     = chain_h[i];
            wv[i + 8] = IV_WORDS[i];
        end
        wv[12] = wv[12] ^ msg_bytes[31:0];
        wv[13] = wv[13] ^ msg_bytes[63:32];
        if (final_blk)
            wv[14] = ~wv[14];
        for (int r = 0; r < 10; r++)
        begin
            g_mix(0, 4,  8, 12, blk_words[SIGMA[r][0]],  blk_words[SIGMA[r][1]]);
            g_mix(1, 5,  9, 13, blk_words[SIGMA[r][2]],  blk_words[SIGMA[r][3]]);
            g_mix(2, 6, 10, 14, blk_words[SIGMA[r][4]],  blk_words[SIGMA[r][5]]);
            g_mix(3, 7, 11, 15, blk_words[SIGMA[r][6]],  blk_words[SIGMA[r][7]]);
            g_mix(0, 5, 10, 15, blk_words[SIGMA[r][8]],  blk_words[SIGMA[r][9]]);
            g_mix(1, 6, 11, 12, blk_words[SIGMA[r][10]], blk_words[SIGMA[r][11]]);
            g_mix(2, 7,  8, 13, blk_words[SIGMA[r][12]], blk_words[SIGMA[r][13]]);
            g_mix(3, 4,  9, 14, blk_words[SIGMA[r][14]], blk_words[SIGMA[r][15]]);
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] ^ wv[i] ^ wv[i + 8];
    endfunction

    // A full block is only compressed once another byte shows up
    function automatic void append_byte(input logic [7:0] b);
        if (blk_fill >= 64)
        begin
            msg_bytes = msg_bytes + 64'd64;
            hash_compress(1'b0);
            for (int i = 0; i < 16; i++)
                blk_words[i] = '0;
            blk_fill = 0;
        end
        blk_words[blk_fill >> 2] = blk_words[blk_fill >> 2]
                                   | (word_t'(b) << (8 * (blk_fill & 3)));
        blk_fill++;
    endfunction

    // Absorb one accepted word; on end of message queue the digest words
    function automatic void hash_absorb_word(input word_t data, input logic [2:0] cnt,
                                             input logic eom);
        int      nb;
        int      len;
        int      nw;
        int      have;
        digest_t d;
        nb = (cnt > 3'd4) ? 4 : int'(cnt);
        if (msg_bytes == 64'd0 && blk_fill == 0)
            load_chain();
        for (int i = 0; i < nb; i++)
            append_byte(data[8 * i +: 8]);
        if (!eom)
            return;
        msg_bytes = msg_bytes + 64'(blk_fill);
        hash_compress(1'b1);
        len = digest_bytes();
        nw  = (len + 3) >> 2;
        for (int i = 0; i < nw; i++)
        begin
            d.word = chain_h[i];
            have   = len - 4 * i;
            if (have < 4)
                d.word = d.word & ((32'd1 << (8 * have)) - 32'd1);
            d.last = (i + 1 == nw);
            digest_q.push_back(d);
        end
        fresh_message();
    endfunction

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: end the run as a failure if it has not finished by this time
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic int draw_gap(input bit burst);
        if (burst || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Offer one word and hold it until accepted, then advance the model
    task automatic send_word(input word_t data, input logic [2:0] cnt, input logic eom);
        int gap;
        if ($urandom_range(0, 24) == 0)
            src_burst = ~src_burst;
        gap = draw_gap(src_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, cnt, data};
        s_tlast  <= eom;
        do @(posedge clk); while (!s_tready);
        hash_absorb_word(data, cnt, eom);
        n_words++;
        if (eom)
            n_msgs++;
    endtask

    // Drop valid, wait for every owed digest word, then let the core go idle
    task automatic settle_engine();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_OUT_LEN)
            cfg_out_len = val[5:0];
        else
            cfg_key_len = val[5:0];
        n_reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One well-formed message: optional padded key block, then the body
    task automatic send_message(input bit short_only);
        int          kb;
        int          body;
        int          pick;
        word_t       w;
        logic [2:0]  c;
        kb = key_bytes();
        if (kb != 0)
        begin
            n_keyed++;
            for (int i = 0; i < 16; i++)
            begin
                w = $urandom;
                for (int b = 0; b < 4; b++)
                    if (4 * i + b >= kb)
                        w[8 * b +: 8] = 8'h00;
                send_word(w, 3'd4, 1'b0);
            end
        end
        pick = $urandom_range(0, 99);
        if (short_only)
            body = $urandom_range(1, 2);
        else if (pick < 60)
            body = $urandom_range(1, 6);
        else if (pick < 80)
            body = $urandom_range(7, 20);
        else if (pick < 90)
            body = $urandom_range(21, 40);
        else
            body = 16;   // exactly one block, no spill
        for (int i = 0; i < body; i++)
        begin
            if (i == body - 1)
            begin
                if (!short_only && pick >= 90)
                    c = 3'd4;
                else if ($urandom_range(0, 7) == 0)
                    c = 3'($urandom_range(5, 7));
                else
                    c = 3'($urandom_range(0, 4));
            end
            else if ($urandom_range(0, 19) == 0)
                c = 3'($urandom_range(0, 7));   // odd-sized word inside the message
            else
                c = 3'd4;
            send_word($urandom, c, i == body - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Digest side: random hold-offs, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : digest_sink
        int      gap;
        digest_t exp_d;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(negedge clk);
                sink_hold = 0;
            end
            if ($urandom_range(0, 29) == 0)
                sink_burst = ~sink_burst;
            gap = draw_gap(sink_burst);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            n_digest++;
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h (last=%0b)", m_tdata, m_tlast);
                err_cnt++;
            end
            else
            begin
                exp_d = digest_q.pop_front();
                if (m_tdata !== exp_d.word)
                begin
                    $error("digest_word mismatch: expected %h, got %h", exp_d.word, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== exp_d.last)
                begin
                    $error("digest_last mismatch: expected %0b, got %0b", exp_d.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int          phase_start;
        logic        last_rep;
        logic [31:0] wd;
        int          ol;
        int          kl;
        digest_t     kd;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        err_cnt      = 0;
        n_words      = 0;
        n_msgs       = 0;
        n_keyed      = 0;
        n_digest     = 0;
        n_reg_writes = 0;
        sink_hold    = 0;
        src_burst    = 1'b0;
        sink_burst   = 1'b0;

        // Registers come out of reset at 32-byte digest, no key
        cfg_out_len = 6'd32;
        cfg_key_len = 6'd0;
        fresh_message();
        for (int i = 0; i < 16; i++)
            wv[i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; known-answer rows replace the model's digest
        // with the published one
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_tab[r].kind == ROW_WORD)
            begin
                for (int k = 0; k < dir_tab[r].reps; k++)
                begin
                    last_rep = dir_tab[r].eom && (k == dir_tab[r].reps - 1);
                    send_word(dir_tab[r].data, dir_tab[r].cnt, last_rep);
                    if (last_rep && dir_tab[r].kat != KAT_NONE)
                    begin
                        // Known-answer rows run at the full 32-byte digest; drop
                        // the eight words just queued for this message
                        repeat (8)
                            void'(digest_q.pop_back());
                        for (int i = 0; i < 8; i++)
                        begin
                            kd.word = (dir_tab[r].kat == KAT_EMPTY_MSG) ? EMPTY_DIGEST[i]
                                                                        : ABC_DIGEST[i];
                            kd.last = (i == 7);
                            digest_q.push_back(kd);
                        end
                    end
                end
            end
            else
            begin
                // Registers only change with the engine idle
                settle_engine();
                reg_write((dir_tab[r].kind == ROW_OUT_LEN) ? ADDR_OUT_LEN : ADDR_KEY_LEN,
                          dir_tab[r].data);
            end
        end

        // Random phases: new register settings each time, extremes first
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin ol = 1;  kl = 0;  end
                1:       begin ol = 32; kl = 32; end
                2:       begin ol = 0;  kl = 63; end
                3:       begin ol = 63; kl = 0;  end
                4:       begin ol = 17; kl = 0;  end
                5:       begin ol = 8;  kl = 1;  end
                6:       begin ol = 33; kl = 40; end
                default:
                begin
                    ol = $urandom_range(0, 63);
                    kl = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 63);
                end
            endcase
            settle_engine();
            wd = $urandom;
            wd[5:0] = 6'(ol);
            reg_write(ADDR_OUT_LEN, wd);
            wd = $urandom;
            wd[5:0] = 6'(kl);
            reg_write(ADDR_KEY_LEN, wd);

            phase_start = n_words;
            if (p == 4)
            begin
                // Back-pressure: hold the digest side off for a long stretch
                // while short messages keep coming, so the input stalls
                sink_hold = HOLD_CYCLES;
                src_burst = 1'b1;
                while (n_words - phase_start < PHASE_WORDS)
                    send_message(1'b1);
                src_burst = 1'b0;
            end
            else
            begin
                while (n_words - phase_start < PHASE_WORDS)
                    send_message(1'b0);
            end
        end

        // Drain; extra time catches any stray digest words
        settle_engine();

        $display("Sent %0d words in %0d messages (%0d keyed), %0d register writes.",
                 n_words, n_msgs, n_keyed, n_reg_writes);
        $display("Checked %0d digest words across ten register settings, %0d errors.",
                 n_digest, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/b2s_pkg.sv
hw/rtl/b2s_mix_unit.sv
hw/rtl/b2s_compress_core.sv
hw/rtl/blake2s_hash_engine_top.sv
tb/tb_blake2s_hash_engine_top.sv
